// ===== rtl/pr_pkg.sv =====
// shared types and constants for the packet resequencer
package pr_pkg;

   localparam int HOLD_DEPTH_DEF = 16;
   localparam logic [31:0] SEQ_START = 32'd1;

   typedef struct packed {
      logic [31:0] seq_num;
      logic [15:0] packet_tag;
      logic [9:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [31:0] out_seq;
      logic [15:0] out_tag;
      logic [9:0]  out_count;
      logic        from_store;
      logic        last_of_run;
   } rsp_type;

   // one held packet
   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] tag;
      logic [9:0]  count;
   } entry_type;

   // search chain between neighboring cells
   typedef struct packed {
      logic      taken;
      entry_type entry;
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ===== rtl/pr_cell.sv =====
// one hold cell: entry storage, local match and priority hand-off
module pr_cell import pr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  entry_type   wr_entry,
   input  logic        search_en,
   input  logic [31:0] expected,
   input  link_type    link_in,
   output link_type    link_out,
   output logic        grant
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit;

   assign hit   = valid_ff && (entry_ff.seq == expected);
   assign grant = search_en && hit && !link_in.taken;

   // lower cells win, so a hit here only passes on if nothing below took it
   always_comb begin
      link_out.taken = link_in.taken || hit;
      link_out.entry = grant ? entry_ff : link_in.entry;
   end

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (wr_en) begin
         valid_in = 1'b1;
         entry_in = wr_entry;
      end else if (grant) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/packet_resequencer.sv =====
// top level of the packet resequencer: control, expected number and cell row
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_data          in         start && !busy
//   response  rsp_strobe, rsp_data           out        rsp_strobe, one cycle
//
// a packet that is stored or discarded is taken with busy staying low
// an in-order packet raises busy while k held entries are drained (k <= HOLD_DEPTH),
// one search of the cell row per cycle; one word leaves per search
// reset is synchronous and active high; the row comes up with all entries empty
// the receiver cannot stall: each word is strobed by rsp_strobe for exactly one cycle
module packet_resequencer import pr_pkg::*; #(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int PTR_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HOLD_DEPTH - 1);

   state_type         state_ff, state_in;
   logic [31:0]       expected_ff, expected_in;
   logic [PTR_W-1:0]  write_pos_ff, write_pos_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              in_order;
   logic              store_it;
   logic              search_en;
   logic              hit_any;
   entry_type         wr_entry;
   link_type          link [HOLD_DEPTH+1];
   logic [HOLD_DEPTH-1:0] grant_vec;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign in_order   = (req_data.seq_num == expected_ff);
   // ahead of the expected number: hold it; behind: drop it
   assign store_it   = accept && (req_data.seq_num > expected_ff);
   assign search_en  = (state_ff == ST_DRAIN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign wr_entry.seq   = req_data.seq_num;
   assign wr_entry.tag   = req_data.packet_tag;
   assign wr_entry.count = req_data.byte_count;

   // search chain starts empty at cell 0 (lowest index has priority)
   assign link[0] = '0;

   for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
      pr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (store_it && (write_pos_ff == PTR_W'(i))),
         .wr_entry  (wr_entry),
         .search_en (search_en),
         .expected  (expected_ff),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .grant     (grant_vec[i])
      );
   end

   assign hit_any = search_en && link[HOLD_DEPTH].taken;

   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      write_pos_in  = write_pos_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_order) begin
               // direct delivery is held in pend until the row search shows if it ends the run
               pend_in.out_seq     = req_data.seq_num;
               pend_in.out_tag     = req_data.packet_tag;
               pend_in.out_count   = req_data.byte_count;
               pend_in.from_store  = 1'b0;
               pend_in.last_of_run = 1'b0;
               expected_in         = expected_ff + 32'd1;
               state_in            = ST_DRAIN;
            end else if (store_it) begin
               // ring write, overwrites the slot written longest ago, held or not
               write_pos_in = (write_pos_ff == PTR_LAST) ? '0 : write_pos_ff + PTR_W'(1);
            end
         end
         ST_DRAIN: begin
            // send the pending word, marked last when nothing more matches
            rsp_strobe_in           = 1'b1;
            rsp_data_in             = pend_ff;
            rsp_data_in.last_of_run = !hit_any;
            if (hit_any) begin
               pend_in.out_seq     = link[HOLD_DEPTH].entry.seq;
               pend_in.out_tag     = link[HOLD_DEPTH].entry.tag;
               pend_in.out_count   = link[HOLD_DEPTH].entry.count;
               pend_in.from_store  = 1'b1;
               pend_in.last_of_run = 1'b0;
               expected_in         = expected_ff + 32'd1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= SEQ_START;
         write_pos_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         write_pos_ff  <= write_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // at most one cell hands its entry out per search
   a_one_grant : assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant_vec))
      else $error("more than one cell granted");

   // a search without a hit closes the run with a last word
   a_close_run : assert property (@(posedge clock) disable iff (reset)
      (search_en && !hit_any) |=> (rsp_strobe && rsp_data.last_of_run && !busy))
      else $error("run not closed after failed search");

   // a word that is not last means the drain is still going
   a_more_follow : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_of_run) |-> busy)
      else $error("non-last word with drain finished");

   // each delivery from the row advances the expected number by one
   a_advance : assert property (@(posedge clock) disable iff (reset)
      hit_any |=> (expected_ff == $past(expected_ff) + 32'd1))
      else $error("expected number did not advance");

   // storing a packet produces no word and leaves the block free
   a_store_quiet : assert property (@(posedge clock) disable iff (reset)
      store_it |=> (!busy && !rsp_strobe))
      else $error("store caused activity");

endmodule

// ===== test/tb_packet_resequencer.sv =====
// self-checking testbench for the packet resequencer, with its delivery scoreboard
`timescale 1ns / 100ps

// predicts deliveries from accepted packets and checks each delivered word in order
class delivery_board;
   localparam int DEPTH = pr_pkg::HOLD_DEPTH_DEF;

   pr_pkg::rsp_type due[$];
   logic [31:0]     next_seq;
   logic [31:0]     held_seq   [DEPTH];
   logic [15:0]     held_tag   [DEPTH];
   logic [9:0]      held_count [DEPTH];
   bit              held_ok    [DEPTH];
   int unsigned     wr_pos;
   int              mismatches;

   function new();
      next_seq   = pr_pkg::SEQ_START;
      wr_pos     = 0;
      mismatches = 0;
      for (int i = 0; i < DEPTH; i++) begin
         held_seq[i]   = '0;
         held_tag[i]   = '0;
         held_count[i] = '0;
         held_ok[i]    = 1'b0;
      end
   endfunction

   function int pending();
      return due.size();
   endfunction

   // work out the deliveries caused by one accepted packet
   function void note(pr_pkg::req_type w);
      pr_pkg::rsp_type r;
      int hit;
      if (w.seq_num == next_seq) begin
         r.out_seq     = w.seq_num;
         r.out_tag     = w.packet_tag;
         r.out_count   = w.byte_count;
         r.from_store  = 1'b0;
         r.last_of_run = 1'b0;
         next_seq++;
         for (int pass = 0; pass < DEPTH; pass++) begin
            hit = -1;
            for (int i = 0; i < DEPTH; i++) begin
               if (held_ok[i] && held_seq[i] == next_seq) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) break;
            due.push_back(r);
            r.out_seq     = held_seq[hit];
            r.out_tag     = held_tag[hit];
            r.out_count   = held_count[hit];
            r.from_store  = 1'b1;
            held_ok[hit]  = 1'b0;
            next_seq++;
         end
         r.last_of_run = 1'b1;
         due.push_back(r);
      end else if (w.seq_num > next_seq) begin
         held_seq[wr_pos]   = w.seq_num;
         held_tag[wr_pos]   = w.packet_tag;
         held_count[wr_pos] = w.byte_count;
         held_ok[wr_pos]    = 1'b1;
         wr_pos = (wr_pos + 1) % DEPTH;
      end
   endfunction

   function void check(pr_pkg::rsp_type got);
      pr_pkg::rsp_type want;
      bit bad;
      if (due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: seq %h tag %h count %0d store %b last %b",
                     got.out_seq, got.out_tag, got.out_count, got.from_store,
                     got.last_of_run);
         return;
      end
      want = due.pop_front();
      bad  = (got.out_seq !== want.out_seq) || (got.out_tag !== want.out_tag)
          || (got.out_count !== want.out_count) || (got.from_store !== want.from_store)
          || (got.last_of_run !== want.last_of_run);
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h/%h/%0d/%b/%b got %h/%h/%0d/%b/%b",
                     want.out_seq, want.out_tag, want.out_count, want.from_store,
                     want.last_of_run, got.out_seq, got.out_tag, got.out_count,
                     got.from_store, got.last_of_run);
      end
   endfunction
endclass

module tb_packet_resequencer;
   import pr_pkg::*;

   localparam int DEPTH       = HOLD_DEPTH_DEF;
   localparam int QUIET_LIMIT = 2000;  // cycles with no word moving before giving up
   localparam int TAIL_CYCLES = 40;    // idle tail after the last phase, before the verdict
   localparam int PHASE_WORDS = 26;    // at least this many random words in each of the four phases

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   delivery_board board = new();

   int idle_pct = 0;   // chance in a hundred that the sender idles a cycle
   int sent     = 0;   // packets accepted so far

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   packet_resequencer #(.HOLD_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // every strobed word is checked at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check(rsp_data);
   end

   // watchdog: a long run with no word moving either way means a hang
   initial begin : watchdog
      int quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type make_word(logic [31:0] seq, logic [15:0] tag,
                                         logic [9:0] cnt);
      req_type w;
      w.seq_num    = seq;
      w.packet_tag = tag;
      w.byte_count = cnt;
      return w;
   endfunction

   // counts above 512 are legal on the port and pass through unchanged
   function automatic logic [9:0] pick_count();
      if ($urandom_range(0, 9) == 0) return 10'($urandom_range(513, 1023));
      return 10'($urandom_range(0, 512));
   endfunction

   function automatic req_type rand_word(logic [31:0] seq);
      return make_word(seq, 16'($urandom_range(0, 65535)), pick_count());
   endfunction

   // offer one word, idling first at the phase's rate, and hold it until taken
   task automatic put_word(input req_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!(start && !busy));
      // the predictor runs here only, so its state is settled when this returns
      board.note(w);
      sent++;
   endtask

   // sender holds off until every predicted delivery has come out
   task automatic drain_pause();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // the next n numbers in shuffled order; a broken window loses one
   // number and may repeat some others, leaving a gap and duplicates held
   task automatic send_window(input int n, input bit broken);
      logic [31:0] order [DEPTH];
      logic [31:0] tmp;
      int          drop;
      int          j;
      for (int i = 0; i < n; i++) order[i] = board.next_seq + 32'(i);
      for (int i = n - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      drop = broken ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         if (i != drop) put_word(rand_word(order[i]));
         if (i != drop && broken && $urandom_range(0, 3) == 0)
            put_word(rand_word(order[i]));
      end
   endtask

   initial begin : stimulus
      int pct [4] = '{0, 49, 0, 38};
      int phase_start;
      int pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      put_word(make_word(32'h0000_0000, 16'h0000, 10'd0));      // below expected: dropped
      put_word(make_word(32'hFFFF_FFFF, 16'hFFFF, 10'd1023));   // far ahead: held, count > 512
      put_word(make_word(32'd1, 16'h1234, 10'd512));            // in order, no held match
      put_word(make_word(32'd3, 16'hA5A5, 10'd5));
      put_word(make_word(32'd4, 16'h5A5A, 10'd300));
      put_word(make_word(32'd2, 16'h0F0F, 10'd64));             // drains 3 and 4
      // duplicate held numbers: the lower slot goes first, the other stays behind
      put_word(make_word(32'd6, 16'h0006, 10'd100));
      put_word(make_word(32'd6, 16'h0066, 10'd200));
      put_word(make_word(32'd5, 16'h0005, 10'd511));
      // fill the whole ring, overwriting everything older, then release it in one run
      for (int s = 23; s >= 8; s--) put_word(rand_word(32'(s)));
      put_word(make_word(32'd7, 16'hFFFF, 10'd0));
      drain_pause();

      // random part in four phases, two of them idling, with a full drain between phases
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct    = pct[ph];
         phase_start = sent;
         while (sent - phase_start < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               send_window($urandom_range(1, DEPTH), 1'b0);
            else if (pick < 75)
               send_window($urandom_range(2, DEPTH), 1'b1);
            else if (pick < 85)
               put_word(rand_word($urandom()));                // noise, mostly far ahead
            else if (pick < 92)
               put_word(rand_word($urandom_range(0, board.next_seq - 1)));  // stale
            else
               put_word(rand_word(board.next_seq + $urandom_range(1, 24)));  // gap
         end
         drain_pause();
      end

      // let any stray word show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
